// ===== sv/sac_pkg.sv =====
// Shared constants and the set 1 key translation function for the scancode translator.
`default_nettype none

package sac_pkg;

    // Default ring size; the ring holds one entry fewer than this.
    localparam int DEPTH_DEF = 256;

    localparam int CHAR_W = 7;
    localparam int CODE_W = 8;

    // Item kinds carried on the input tuser bit.
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Scancodes with a special meaning.
    localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [CODE_W-1:0] SC_CAPS_MAKE    = 8'h3A;

    // ASCII bounds of the lower-case letters that the table returns.
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 7'h7A;

    // UK layout lookup of a make code. Letters always come back in lower case;
    // their case is settled afterwards from shift and caps lock.
    function automatic logic [CHAR_W-1:0] key_char(input logic [6:0] code,
                                                   input logic shifted);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        case (code)
            7'h01: ch = 7'h1B;                       // escape
            7'h02: ch = shifted ? 7'h21 : 7'h31;     // ! 1
            7'h03: ch = shifted ? 7'h22 : 7'h32;     // " 2
            7'h04: ch = shifted ? 7'h23 : 7'h33;     // # 3
            7'h05: ch = shifted ? 7'h24 : 7'h34;     // $ 4
            7'h06: ch = shifted ? 7'h25 : 7'h35;     // % 5
            7'h07: ch = shifted ? 7'h5E : 7'h36;     // ^ 6
            7'h08: ch = shifted ? 7'h26 : 7'h37;     // & 7
            7'h09: ch = shifted ? 7'h2A : 7'h38;     // * 8
            7'h0A: ch = shifted ? 7'h28 : 7'h39;     // ( 9
            7'h0B: ch = shifted ? 7'h29 : 7'h30;     // ) 0
            7'h0C: ch = shifted ? 7'h5F : 7'h2D;     // _ -
            7'h0D: ch = shifted ? 7'h7E : 7'h5E;     // ~ ^
            7'h0E: ch = 7'h08;                       // backspace
            7'h0F: ch = 7'h09;                       // tab
            7'h10: ch = 7'h71;
            7'h11: ch = 7'h77;
            7'h12: ch = 7'h65;
            7'h13: ch = 7'h72;
            7'h14: ch = 7'h74;
            7'h15: ch = 7'h79;
            7'h16: ch = 7'h75;
            7'h17: ch = 7'h69;
            7'h18: ch = 7'h6F;
            7'h19: ch = 7'h70;
            7'h1A: ch = shifted ? 7'h7B : 7'h5B;     // { [
            7'h1B: ch = shifted ? 7'h7D : 7'h5D;     // } ]
            7'h1C: ch = 7'h0A;                       // enter
            7'h1E: ch = 7'h61;
            7'h1F: ch = 7'h73;
            7'h20: ch = 7'h64;
            7'h21: ch = 7'h66;
            7'h22: ch = 7'h67;
            7'h23: ch = 7'h68;
            7'h24: ch = 7'h6A;
            7'h25: ch = 7'h6B;
            7'h26: ch = 7'h6C;
            7'h27: ch = shifted ? 7'h3A : 7'h3B;     // : ;
            7'h28: ch = shifted ? 7'h7E : 7'h40;     // ~ @
            7'h29: ch = shifted ? 7'h00 : 7'h23;     // nothing, #
            7'h2B: ch = shifted ? 7'h7C : 7'h5C;     // | backslash
            7'h2C: ch = 7'h7A;
            7'h2D: ch = 7'h78;
            7'h2E: ch = 7'h63;
            7'h2F: ch = 7'h76;
            7'h30: ch = 7'h62;
            7'h31: ch = 7'h6E;
            7'h32: ch = 7'h6D;
            7'h33: ch = shifted ? 7'h3C : 7'h2C;     // < ,
            7'h34: ch = shifted ? 7'h3E : 7'h2E;     // > .
            7'h35: ch = shifted ? 7'h3F : 7'h2F;     // ? /
            7'h37: ch = 7'h2A;                       // keypad *
            7'h39: ch = 7'h20;                       // space
            7'h47: ch = 7'h37;                       // keypad digits and signs
            7'h48: ch = 7'h38;
            7'h49: ch = 7'h39;
            7'h4A: ch = 7'h2D;
            7'h4B: ch = 7'h34;
            7'h4C: ch = 7'h35;
            7'h4D: ch = 7'h36;
            7'h4E: ch = 7'h2B;
            7'h4F: ch = 7'h31;
            7'h50: ch = 7'h32;
            7'h51: ch = 7'h33;
            7'h52: ch = 7'h30;
            7'h53: ch = 7'h2E;
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sac_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/scancode_to_ascii_fifo_core.sv =====
// Top level: set 1 scancode translator with shift/caps tracking and a character ring buffer.
//
//  Channel  | Dir | Signals                         | Beat contents
//  ---------+-----+---------------------------------+----------------------------------------
//  s (in)   | in  | i_s_tvalid o_s_tready           | tdata: scancode[7:0]
//           |     | i_s_tdata[7:0] i_s_tuser        | tuser: operation (0 scancode, 1 read)
//  m (out)  | out | o_m_tvalid i_m_tready           | tdata: character[6:0], character_valid[7],
//           |     | o_m_tdata[15:0]                 |        overrun[8], buffer_nonempty[9]
//
// Every input beat produces exactly one output beat. The block sustains one beat per
// cycle while the output is ready; a result passes through stage A, where the registered
// read of the character RAM completes, then stage B. Two result stages sit between the
// sides, so input is still taken while one finished result waits on a stalled output.
// Reset (i_rst_n low, synchronous) empties the ring and clears shift and caps lock;
// the RAM contents are not cleared and no clearing pass is needed.
`default_nettype none

module scancode_to_ascii_fifo_core #(
    parameter int DEPTH = sac_pkg::DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] scancode
    input  wire logic        i_s_tuser,   // [0] operation
    // Output stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // [6:0] character, [7] character_valid,
                                          // [8] overrun, [9] buffer_nonempty, rest zero
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CHAR_W = sac_pkg::CHAR_W;
    localparam int RES_W  = CHAR_W + 3;

    // Ring pointers and key state.
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic             r_lshift, n_lshift;
    logic             r_rshift, n_rshift;
    logic             r_caps, n_caps;

    // Stage A: flags of the accepted beat while the RAM read completes.
    logic             r_a_valid;
    logic             r_a_char_valid;
    logic             r_a_overrun;
    logic             r_a_nonempty;

    // Stage B: the finished result on the output port.
    logic             r_b_valid;
    logic [RES_W-1:0] r_b_data;

    logic             s_accept;
    logic             b_load;

    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_next;
    logic             shifted;
    logic             upper;
    logic [CHAR_W-1:0] raw_char;
    logic [CHAR_W-1:0] key_ch;
    logic             alpha_key;
    logic             push;
    logic             pop;
    logic             overrun;
    logic [CHAR_W-1:0] ram_rd_data;

    // Stage A may move on when stage B is empty or is being drained.
    assign b_load     = r_a_valid && (!r_b_valid || i_m_tready);
    assign o_s_tready = !r_a_valid || b_load;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Ring pointers wrap at DEPTH, which need not be a power of two.
    assign wr_next = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign rd_next = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // Translation: table lookup, then letters take upper case when caps lock and
    // shift disagree. Bit 5 is the ASCII case bit.
    assign shifted   = r_lshift || r_rshift;
    assign upper     = r_caps ^ shifted;
    assign raw_char  = sac_pkg::key_char(i_s_tdata[6:0], shifted);
    assign alpha_key = (raw_char >= sac_pkg::ASCII_LOWER_A) &&
                       (raw_char <= sac_pkg::ASCII_LOWER_Z);
    assign key_ch    = alpha_key ? {raw_char[6], ~upper, raw_char[4:0]} : raw_char;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_lshift = r_lshift;
        n_rshift = r_rshift;
        n_caps   = r_caps;
        push     = 1'b0;
        pop      = 1'b0;
        overrun  = 1'b0;
        if (s_accept) begin
            if (i_s_tuser == sac_pkg::OP_READ) begin
                if (r_wr_ptr != r_rd_ptr) begin
                    pop      = 1'b1;
                    n_rd_ptr = rd_next;
                end
            end else if (i_s_tdata == sac_pkg::SC_LSHIFT_MAKE) begin
                n_lshift = 1'b1;
            end else if (i_s_tdata == sac_pkg::SC_RSHIFT_MAKE) begin
                n_rshift = 1'b1;
            end else if (i_s_tdata == sac_pkg::SC_LSHIFT_BREAK) begin
                n_lshift = 1'b0;
            end else if (i_s_tdata == sac_pkg::SC_RSHIFT_BREAK) begin
                n_rshift = 1'b0;
            end else if (i_s_tdata == sac_pkg::SC_CAPS_MAKE) begin
                n_caps = !r_caps;
            end else if (!i_s_tdata[7] && (key_ch != '0)) begin
                // A full ring keeps one slot free, so it drops the character.
                if (wr_next != r_rd_ptr) begin
                    push     = 1'b1;
                    n_wr_ptr = wr_next;
                end else begin
                    overrun = 1'b1;
                end
            end
        end
    end

    // Character store. A single beat either writes or reads, and a write is
    // visible to a read issued on the following cycle.
    sac_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (push),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (key_ch),
        .i_rd_en   (pop),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_lshift  <= 1'b0;
            r_rshift  <= 1'b0;
            r_caps    <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_lshift <= n_lshift;
            r_rshift <= n_rshift;
            r_caps   <= n_caps;
            if (s_accept) begin
                r_a_valid <= 1'b1;
            end else if (b_load) begin
                r_a_valid <= 1'b0;
            end
            if (b_load) begin
                r_b_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // Payload registers. The RAM output holds while stage A stalls, because a
    // read is only issued when a new beat is taken.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_char_valid <= pop;
            r_a_overrun    <= overrun;
            r_a_nonempty   <= (n_wr_ptr != n_rd_ptr);
        end
        if (b_load) begin
            r_b_data <= {r_a_nonempty, r_a_overrun, r_a_char_valid,
                         r_a_char_valid ? ram_rd_data : {CHAR_W{1'b0}}};
        end
    end

    assign o_m_tvalid = r_b_valid;
    assign o_m_tdata  = {{(16 - RES_W){1'b0}}, r_b_data};

endmodule

`default_nettype wire
